@@ sv/vwpr_pkg.sv @@
package vwpr_pkg;

  // screen geometry
  localparam int ScreenWidth  = 256;
  localparam int ScreenHeight = 192;

  localparam int TextCellRows = 12;
  localparam logic [3:0] TEXT_LAST_ROW = 4'(TextCellRows - 1);
  localparam logic [12:0] TEXT_BYTES = 13'((ScreenWidth / 8) * (ScreenHeight / TextCellRows));

  localparam logic [4:0] COUNT_NARROW = 5'd8;
  localparam logic [4:0] COUNT_WIDE   = 5'd16;

  // register indexes on the config port
  localparam logic REG_GRAPHICS_ENABLE = 1'b0;
  localparam logic REG_GRAPHICS_MODE   = 1'b1;

  // item as held by the row stage
  typedef struct packed {
    logic       gfx;
    logic [2:0] mode;
    logic [7:0] data;
  } vwpr_item_t;

  // per bitmap mode geometry
  typedef struct packed {
    logic        two_bit;    // four 2-bit pixels per byte, else eight 1-bit
    logic [1:0]  xpix_log2;  // horizontal replication
    logic        bpl32;      // 32 bytes per line, else 16
    logic [1:0]  ypix;       // screen rows per mode row
    logic        wide;       // 16 screen pixels per byte, else 8
    logic [12:0] limit;      // bytes in the active screen
  } vwpr_mode_t;

  function automatic vwpr_mode_t mode_info(input logic [2:0] mode);
    vwpr_mode_t mi;
    case (mode)
      3'd0: mi = '{1'b1, 2'd2, 1'b0, 2'd3, 1'b1, 13'd1024};
      3'd1: mi = '{1'b0, 2'd1, 1'b0, 2'd3, 1'b1, 13'd1024};
      3'd2: mi = '{1'b1, 2'd1, 1'b1, 2'd3, 1'b0, 13'd2048};
      3'd3: mi = '{1'b0, 2'd1, 1'b0, 2'd2, 1'b1, 13'd1536};
      3'd4: mi = '{1'b1, 2'd1, 1'b1, 2'd2, 1'b0, 13'd3072};
      3'd5: mi = '{1'b0, 2'd1, 1'b0, 2'd1, 1'b1, 13'd3072};
      3'd6: mi = '{1'b1, 2'd1, 1'b1, 2'd1, 1'b0, 13'd6144};
      default: mi = '{1'b0, 2'd0, 1'b1, 2'd1, 1'b0, 13'd6144};
    endcase
    return mi;
  endfunction

  // 5x7 font, row 0 on top, leftmost pixel in bit 4
  localparam logic [4:0] GLYPH_ROWS [64][7] = '{
    '{5'd14,5'd17,5'd1,5'd13,5'd21,5'd21,5'd14}, '{5'd4,5'd10,5'd17,5'd17,5'd31,5'd17,5'd17},
    '{5'd30,5'd9,5'd9,5'd14,5'd9,5'd9,5'd30},    '{5'd14,5'd17,5'd16,5'd16,5'd16,5'd17,5'd14},
    '{5'd30,5'd9,5'd9,5'd9,5'd9,5'd9,5'd30},     '{5'd31,5'd16,5'd16,5'd28,5'd16,5'd16,5'd31},
    '{5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd16},'{5'd15,5'd16,5'd16,5'd19,5'd17,5'd17,5'd15},
    '{5'd17,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17},'{5'd14,5'd4,5'd4,5'd4,5'd4,5'd4,5'd14},
    '{5'd1,5'd1,5'd1,5'd17,5'd17,5'd10,5'd4},    '{5'd17,5'd18,5'd20,5'd24,5'd24,5'd20,5'd18},
    '{5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd31},'{5'd17,5'd27,5'd21,5'd17,5'd17,5'd17,5'd17},
    '{5'd17,5'd25,5'd21,5'd19,5'd17,5'd17,5'd17},'{5'd14,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14},
    '{5'd30,5'd17,5'd17,5'd30,5'd16,5'd16,5'd16},'{5'd14,5'd17,5'd17,5'd17,5'd21,5'd18,5'd13},
    '{5'd30,5'd17,5'd17,5'd30,5'd20,5'd18,5'd17},'{5'd14,5'd17,5'd8,5'd4,5'd2,5'd17,5'd14},
    '{5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4},      '{5'd17,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14},
    '{5'd17,5'd17,5'd17,5'd17,5'd10,5'd10,5'd4}, '{5'd17,5'd17,5'd17,5'd17,5'd21,5'd27,5'd17},
    '{5'd17,5'd17,5'd10,5'd4,5'd10,5'd17,5'd17}, '{5'd17,5'd17,5'd10,5'd4,5'd4,5'd4,5'd4},
    '{5'd31,5'd1,5'd2,5'd4,5'd8,5'd16,5'd31},    '{5'd14,5'd8,5'd8,5'd8,5'd8,5'd8,5'd14},
    '{5'd16,5'd16,5'd8,5'd4,5'd2,5'd1,5'd1},     '{5'd14,5'd2,5'd2,5'd2,5'd2,5'd2,5'd14},
    '{5'd4,5'd14,5'd31,5'd4,5'd4,5'd4,5'd4},     '{5'd0,5'd4,5'd8,5'd31,5'd8,5'd4,5'd0},
    '{5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd0},       '{5'd4,5'd4,5'd4,5'd4,5'd4,5'd0,5'd4},
    '{5'd10,5'd10,5'd0,5'd0,5'd0,5'd0,5'd0},     '{5'd10,5'd10,5'd27,5'd0,5'd27,5'd10,5'd10},
    '{5'd4,5'd15,5'd16,5'd14,5'd1,5'd30,5'd4},   '{5'd25,5'd25,5'd2,5'd4,5'd8,5'd19,5'd19},
    '{5'd8,5'd20,5'd20,5'd9,5'd22,5'd22,5'd9},   '{5'd4,5'd4,5'd0,5'd0,5'd0,5'd0,5'd0},
    '{5'd2,5'd4,5'd8,5'd8,5'd8,5'd4,5'd2},       '{5'd8,5'd4,5'd2,5'd2,5'd2,5'd4,5'd8},
    '{5'd0,5'd4,5'd14,5'd31,5'd14,5'd4,5'd0},    '{5'd0,5'd4,5'd4,5'd31,5'd4,5'd4,5'd0},
    '{5'd0,5'd0,5'd0,5'd6,5'd6,5'd2,5'd4},       '{5'd0,5'd0,5'd0,5'd31,5'd0,5'd0,5'd0},
    '{5'd0,5'd0,5'd0,5'd0,5'd0,5'd4,5'd4},       '{5'd1,5'd1,5'd2,5'd4,5'd8,5'd16,5'd16},
    '{5'd4,5'd10,5'd10,5'd10,5'd10,5'd10,5'd4},  '{5'd4,5'd12,5'd4,5'd4,5'd4,5'd4,5'd14},
    '{5'd14,5'd17,5'd1,5'd14,5'd16,5'd16,5'd31}, '{5'd14,5'd17,5'd1,5'd6,5'd1,5'd17,5'd14},
    '{5'd2,5'd6,5'd10,5'd31,5'd2,5'd2,5'd2},     '{5'd31,5'd16,5'd30,5'd1,5'd1,5'd17,5'd14},
    '{5'd14,5'd16,5'd16,5'd30,5'd17,5'd17,5'd14},'{5'd31,5'd1,5'd2,5'd4,5'd8,5'd16,5'd16},
    '{5'd14,5'd17,5'd17,5'd14,5'd17,5'd17,5'd14},'{5'd14,5'd17,5'd17,5'd15,5'd1,5'd1,5'd14},
    '{5'd0,5'd0,5'd4,5'd0,5'd4,5'd0,5'd0},       '{5'd6,5'd6,5'd0,5'd6,5'd6,5'd2,5'd4},
    '{5'd2,5'd4,5'd8,5'd16,5'd8,5'd4,5'd2},      '{5'd0,5'd0,5'd31,5'd0,5'd31,5'd0,5'd0},
    '{5'd16,5'd8,5'd4,5'd2,5'd4,5'd8,5'd16},     '{5'd4,5'd10,5'd2,5'd4,5'd4,5'd0,5'd4}
  };

endpackage

@@ sv/vwpr_row_gen.sv @@
module vwpr_row_gen
  import vwpr_pkg::*;
(
  input  vwpr_item_t  item,
  input  logic [3:0]  row,
  output logic [31:0] pixels,
  output logic [4:0]  pixel_count
);

  vwpr_mode_t mi;
  logic [15:0] text_pix;
  logic [31:0] gfx_pix;
  logic [1:0]  src [8];
  logic [4:0]  gl;
  logic [7:0]  gl_ext;
  logic [3:0]  grow;
  logic        glyph_row_ok;
  logic [1:0]  bg;
  logic [1:0]  wh;
  logic [2:0]  sel;
  logic [2:0]  blk_bit;

  assign mi = mode_info(item.mode);

  // text and semigraphics row
  always_comb begin
    grow         = row - 4'd3;
    glyph_row_ok = (row >= 4'd3) && (row <= 4'd9);
    gl           = glyph_row_ok ? GLYPH_ROWS[item.data[5:0]][grow[2:0]] : 5'd0;
    gl_ext       = {2'b00, gl, 1'b0};
    bg           = item.data[7] ? 2'd3 : 2'd0;
    wh           = item.data[7] ? 2'd0 : 2'd3;
    text_pix     = '0;
    blk_bit      = '0;
    for (int p = 0; p < 8; p++) begin
      if (!item.data[6]) begin
        text_pix[15-2*p -: 2] = gl_ext[7-p] ? ~bg : bg;
      end else begin
        blk_bit = 3'd5 - ({row[3:2], 1'b0} + ((p >= 4) ? 3'd1 : 3'd0));
        if (item.data[blk_bit]) begin
          if (!row[0] && (p % 2 == 0)) begin
            text_pix[15-2*p -: 2] = 2'd3;
          end else begin
            text_pix[15-2*p -: 2] = wh;
          end
        end
      end
    end
  end

  // bitmap row, same for every replicated screen row
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (mi.two_bit) begin
        src[i] = (i < 4) ? item.data[7-2*(i%4) -: 2] : 2'd0;
      end else begin
        src[i] = item.data[7-i] ? 2'd3 : 2'd0;
      end
    end
    gfx_pix = '0;
    sel     = '0;
    for (int j = 0; j < 16; j++) begin
      case (mi.xpix_log2)
        2'd2:    sel = {1'b0, 2'(j / 4)};
        2'd1:    sel = 3'(j / 2);
        default: sel = 3'(j);
      endcase
      if (mi.wide) begin
        gfx_pix[31-2*j -: 2] = src[sel];
      end else if (j < 8) begin
        gfx_pix[15-2*(j%8) -: 2] = src[sel];
      end
    end
  end

  always_comb begin
    if (item.gfx) begin
      pixels      = gfx_pix;
      pixel_count = mi.wide ? COUNT_WIDE : COUNT_NARROW;
    end else begin
      pixels      = {16'h0000, text_pix};
      pixel_count = COUNT_NARROW;
    end
  end

endmodule

@@ sv/video_write_pixel_renderer.sv @@
// video write pixel renderer
//
// start/busy command channel: an item (offset, data) is taken at a rising edge with start
// high and busy low. each write paints row segments of a 256x192 screen; every segment
// appears for exactly one cycle with pixel_strobe high, last marks the final one.
// text mode gives 12 segments of 8 pixels; bitmap modes give 1, 2 or 3 segments of
// 8 or 16 pixels. offsets outside the active screen give nothing.
// the accepted item is held in the item register, and each segment is registered in the
// result register before it is driven. throughput: one segment per cycle from the single
// row generator; the next item is taken in the cycle the current item's last row is built.
// the receiver cannot stall; segments are simply presented and gone.
// apb port: graphics_enable at 0x0, graphics_mode at 0x4, pready always high.
// reset (rst, synchronous) clears both registers and drops any item in flight;
// the mode registers must only be written while the block is idle.
module video_write_pixel_renderer
  import vwpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [12:0] offset,
  input  logic [7:0]  data,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // result channel
  output logic        pixel_strobe,
  output logic [7:0]  x_pos,
  output logic [7:0]  y_pos,
  output logic [4:0]  pixel_count,
  output logic [31:0] pixels,
  output logic        last
);

  // config registers
  logic       graphics_enable;
  logic [2:0] graphics_mode;

  // item register feeding the row generator
  logic       cur_valid;
  vwpr_item_t cur_item;
  logic [7:0] cur_x;
  logic [7:0] cur_ybase;
  logic [3:0] cur_row;
  logic [3:0] cur_last_row;

  logic        accept;
  logic        cfg_write;
  logic        cur_is_last;
  vwpr_mode_t  mi;
  logic        in_range;
  logic [7:0]  line;
  logic [7:0]  x_next;
  logic [7:0]  ybase_next;
  logic [3:0]  last_row_next;
  logic [31:0] row_pixels;
  logic [4:0]  row_count;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_GRAPHICS_MODE) ? {29'd0, graphics_mode}
                                                     : {31'd0, graphics_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      graphics_enable <= 1'b0;
      graphics_mode   <= 3'd0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_GRAPHICS_ENABLE: graphics_enable <= pwdata[0];
        REG_GRAPHICS_MODE:   graphics_mode   <= pwdata[2:0];
        default:             graphics_enable <= graphics_enable;
      endcase
    end
  end

  // busy drops in the cycle the last row is built, so items run back to back
  assign cur_is_last = (cur_row == cur_last_row);
  assign busy        = cur_valid && !cur_is_last;
  assign accept      = start && !busy;

  // screen position of the written byte
  assign mi = mode_info(graphics_mode);

  always_comb begin
    line = mi.bpl32 ? offset[12:5] : offset[11:4];
    if (!graphics_enable) begin
      in_range      = (offset < TEXT_BYTES);
      x_next        = {offset[4:0], 3'b000};
      // cell row times twelve
      ybase_next    = {1'b0, offset[8:5], 3'b000} + {2'b00, offset[8:5], 2'b00};
      last_row_next = TEXT_LAST_ROW;
    end else begin
      in_range      = (offset < mi.limit);
      x_next        = mi.bpl32 ? {offset[4:0], 3'b000} : {offset[3:0], 4'b0000};
      case (mi.ypix)
        2'd3:    ybase_next = line + {line[6:0], 1'b0};
        2'd2:    ybase_next = {line[6:0], 1'b0};
        default: ybase_next = line;
      endcase
      last_row_next = {2'b00, mi.ypix - 2'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (accept) begin
      cur_valid <= in_range;
    end else if (cur_valid && cur_is_last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_item     <= '{graphics_enable, graphics_mode, data};
      cur_x        <= x_next;
      cur_ybase    <= ybase_next;
      cur_row      <= 4'd0;
      cur_last_row <= last_row_next;
    end else if (cur_valid && !cur_is_last) begin
      cur_row <= cur_row + 4'd1;
    end
  end

  vwpr_row_gen u_row_gen (
    .item        (cur_item),
    .row         (cur_row),
    .pixels      (row_pixels),
    .pixel_count (row_count)
  );

  // result register, one segment per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_strobe <= 1'b0;
    end else begin
      pixel_strobe <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_valid) begin
      x_pos       <= cur_x;
      y_pos       <= cur_ybase + {4'd0, cur_row};
      pixel_count <= row_count;
      pixels      <= row_pixels;
      last        <= cur_is_last;
    end
  end

  // a segment that is not the last is always followed by another
  a_rows_contiguous: assert property (@(posedge clk) disable iff (rst)
    (pixel_strobe && !last) |=> pixel_strobe)
    else $error("segment stream broken before last");

  // while busy a row is in progress and must come out next cycle
  a_busy_emits: assert property (@(posedge clk) disable iff (rst)
    busy |=> pixel_strobe)
    else $error("busy without a segment");

  // an on-screen text write shows up once it has passed the item and result registers
  a_text_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && !graphics_enable && (offset[12:9] == 4'd0)) |-> ##2 pixel_strobe)
    else $error("text write produced no segment");

  // narrow segments leave the upper half of pixels clear
  a_narrow_clear: assert property (@(posedge clk) disable iff (rst)
    (pixel_strobe && (pixel_count == COUNT_NARROW)) |-> (pixels[31:16] == 16'h0000))
    else $error("narrow segment has stray upper pixels");

  // only two segment widths exist
  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    pixel_strobe |-> ((pixel_count == COUNT_NARROW) || (pixel_count == COUNT_WIDE)))
    else $error("bad pixel_count");

endmodule
